>>> design/sprite_pixel_blitter_assert.svh
// Assertion macros for the sprite pixel blitter checker.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef SPRITE_PIXEL_BLITTER_ASSERT_SVH
`define SPRITE_PIXEL_BLITTER_ASSERT_SVH

// Check a property on every rising edge outside reset.
`define SPB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define SPB_ASSERT_IMPLIES(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Check that a condition implies another in the next cycle.
`define SPB_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> design/spb_pkg.sv
// Shared types and constants of the sprite pixel blitter.
// Used by the interfaces and all RTL modules; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package spb_pkg;

  // Default store geometry
  localparam int unsigned MAX_WIDTH_DEF  = 128;
  localparam int unsigned MAX_HEIGHT_DEF = 32;

  // Field widths
  localparam int unsigned COORD_W = 12;
  localparam int unsigned GLYPH_W = 8;
  localparam int unsigned COLOR_W = 4;
  localparam int unsigned ATTR_W  = 8;
  localparam int unsigned SW_W    = 8;
  localparam int unsigned SH_W    = 6;
  localparam int unsigned CODE_W  = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  // Upper attribute nibble mask
  localparam logic [ATTR_W-1:0] UPPER_NIBBLE_MASK = 8'd240;

  // Item kinds
  localparam logic KIND_DRAW = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FG_CODE       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_JUMP_FG_CODE  = 2'd3;

  // Register reset values
  localparam logic [SW_W-1:0]   SCREEN_WIDTH_RST  = 8'd80;
  localparam logic [SH_W-1:0]   SCREEN_HEIGHT_RST = 6'd25;
  localparam logic [CODE_W-1:0] FG_CODE_RST       = 4'd1;
  localparam logic [CODE_W-1:0] JUMP_FG_CODE_RST  = 4'd2;

  typedef struct packed {
    logic [SW_W-1:0]   screen_width;
    logic [SH_W-1:0]   screen_height;
    logic [CODE_W-1:0] foreground_code;
    logic [CODE_W-1:0] jump_foreground_code;
  } spb_cfg_t;

  // Controller to datapath commands
  typedef struct packed {
    logic clr_wr;   // write one zero cell of the clearing pass
    logic take;     // latch the input item
    logic look;     // read the addressed cell
    logic commit;   // decide, write the cell, load the result
  } spb_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_last; // clearing pass is at its last cell
    logic out_free; // result register can take a result this cycle
  } spb_stat_t;

endpackage

`default_nettype wire

>>> design/spb_if.sv
// Valid/ready stream interfaces for draw/read items and cell results.
// Depends on spb_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface spb_in_if import spb_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic signed [COORD_W-1:0] col;
  logic signed [COORD_W-1:0] row;
  logic [GLYPH_W-1:0]        glyph;
  logic [COLOR_W-1:0]        color;
  logic [ATTR_W-1:0]         layer_bits;
  logic                      plastic;

  modport source (output valid, kind, col, row, glyph, color, layer_bits, plastic,
                  input ready);
  modport sink   (input valid, kind, col, row, glyph, color, layer_bits, plastic,
                  output ready);
endinterface

interface spb_out_if import spb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               written;
  logic [GLYPH_W-1:0] cell_glyph;
  logic [ATTR_W-1:0]  cell_attr;

  modport source (output valid, written, cell_glyph, cell_attr, input ready);
  modport sink   (input valid, written, cell_glyph, cell_attr, output ready);
endinterface

`default_nettype wire

>>> design/spb_cfg_regs.sv
// Configuration registers of the sprite pixel blitter.
// Depends on spb_pkg for register indexes, widths and reset values.
`timescale 1ns / 1ps
`default_nettype none

module spb_cfg_regs import spb_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output spb_cfg_t                   cfg_o
);

  spb_cfg_t cfg_q, cfg_d;

  // Always take writes
  assign cfg_ready_o = 1'b1;

  // Decode the register index
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_SCREEN_WIDTH:  cfg_d.screen_width         = cfg_data_i[SW_W-1:0];
        REG_SCREEN_HEIGHT: cfg_d.screen_height        = cfg_data_i[SH_W-1:0];
        REG_FG_CODE:       cfg_d.foreground_code      = cfg_data_i[CODE_W-1:0];
        REG_JUMP_FG_CODE:  cfg_d.jump_foreground_code = cfg_data_i[CODE_W-1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.screen_width         <= SCREEN_WIDTH_RST;
      cfg_q.screen_height        <= SCREEN_HEIGHT_RST;
      cfg_q.foreground_code      <= FG_CODE_RST;
      cfg_q.jump_foreground_code <= JUMP_FG_CODE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

>>> design/spb_ctrl.sv
// Controller of the sprite pixel blitter: clearing pass, then one item at a time.
// Depends on spb_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module spb_ctrl import spb_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire spb_stat_t stat_i,
  output spb_cmd_t       cmd_o
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_LOOK  = 2'd2;
  localparam logic [1:0] S_EXEC  = 2'd3;

  logic [1:0] state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd_o.look = 1'b1;
        state_d    = S_EXEC;
      end
      S_EXEC: begin
        // hold until the result register frees up
        if (stat_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> design/spb_datapath.sv
// Datapath of the sprite pixel blitter: item latch, clip, cell stores, result register.
// Depends on spb_pkg for field widths, constants and the command/status structs.
`timescale 1ns / 1ps
`default_nettype none

module spb_datapath import spb_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire spb_cfg_t cfg_i,
  input  wire spb_cmd_t cmd_i,
  output spb_stat_t     stat_o,
  spb_in_if.sink        in_if,
  spb_out_if.source     out_if
);

  localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Latched item
  logic                      kind_q;
  logic signed [COORD_W-1:0] col_q;
  logic signed [COORD_W-1:0] row_q;
  logic [GLYPH_W-1:0]        glyph_q;
  logic [COLOR_W-1:0]        color_q;
  logic [ATTR_W-1:0]         layer_q;
  logic                      plastic_q;

  // Cell stores and registered read data
  logic [GLYPH_W-1:0] glyph_mem [DEPTH];
  logic [ATTR_W-1:0]  attr_mem  [DEPTH];
  logic [GLYPH_W-1:0] rd_glyph_q;
  logic [ATTR_W-1:0]  rd_attr_q;

  // Clearing pass counter
  logic [AW-1:0] clr_q, clr_d;

  // Result register
  logic               out_valid_q, out_valid_d;
  logic               out_written_q;
  logic [GLYPH_W-1:0] out_glyph_q;
  logic [ATTR_W-1:0]  out_attr_q;

  logic [COORD_W-1:0] max_w, max_h, scr_w, scr_h, w_eff, h_eff;
  logic [COORD_W-1:0] col_u, row_u;
  logic               in_area;
  logic [AW-1:0]      addr;
  logic [CODE_W-1:0]  hi;
  logic               protect, do_write;
  logic [ATTR_W-1:0]  new_attr;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [GLYPH_W-1:0] mem_wglyph;
  logic [ATTR_W-1:0]  mem_wattr;

  // Latch the item on transfer
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      kind_q    <= in_if.kind;
      col_q     <= in_if.col;
      row_q     <= in_if.row;
      glyph_q   <= in_if.glyph;
      color_q   <= in_if.color;
      layer_q   <= in_if.layer_bits;
      plastic_q <= in_if.plastic;
    end
  end

  // Clamp the screen size and clip the pixel
  always_comb begin
    max_w = COORD_W'(MAX_WIDTH);
    max_h = COORD_W'(MAX_HEIGHT);
    scr_w = COORD_W'(cfg_i.screen_width);
    scr_h = COORD_W'(cfg_i.screen_height);
    w_eff = (scr_w > max_w) ? max_w : scr_w;
    h_eff = (scr_h > max_h) ? max_h : scr_h;
    col_u = $unsigned(col_q);
    row_u = $unsigned(row_q);
    in_area = !col_q[COORD_W-1] && !row_q[COORD_W-1] && (col_u < w_eff) && (row_u < h_eff);
    addr = AW'(row_u) * AW'(MAX_WIDTH) + AW'(col_u);
  end

  // Decide the draw from the cell as read
  always_comb begin
    hi       = CODE_W'((rd_attr_q & UPPER_NIBBLE_MASK) >> 4);
    protect  = plastic_q && ((hi == cfg_i.foreground_code) ||
                             (hi == cfg_i.jump_foreground_code));
    do_write = in_area && (kind_q == KIND_DRAW) && (color_q != '0) && !protect;
    new_attr = ATTR_W'(color_q) | layer_q;
  end

  // Store write port: clearing pass or commit
  always_comb begin
    mem_we     = cmd_i.clr_wr || (cmd_i.commit && do_write);
    mem_waddr  = cmd_i.clr_wr ? clr_q : addr;
    mem_wglyph = cmd_i.clr_wr ? '0 : glyph_q;
    mem_wattr  = cmd_i.clr_wr ? '0 : new_attr;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      glyph_mem[mem_waddr] <= mem_wglyph;
      attr_mem[mem_waddr]  <= mem_wattr;
    end
    if (cmd_i.look) begin
      rd_glyph_q <= glyph_mem[addr];
      rd_attr_q  <= attr_mem[addr];
    end
  end

  // Advance the clearing pass
  assign clr_d = cmd_i.clr_wr ? clr_q + AW'(1) : clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else begin
      clr_q <= clr_d;
    end
  end

  // Result register: load on commit, drop on transfer
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.commit) begin
      out_valid_d = 1'b1;
    end else if (out_if.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_written_q <= do_write;
      out_glyph_q   <= !in_area ? '0 : (do_write ? glyph_q : rd_glyph_q);
      out_attr_q    <= !in_area ? '0 : (do_write ? new_attr : rd_attr_q);
    end
  end

  assign out_if.valid      = out_valid_q;
  assign out_if.written    = out_written_q;
  assign out_if.cell_glyph = out_glyph_q;
  assign out_if.cell_attr  = out_attr_q;

  assign stat_o.clr_last = (clr_q == AW'(DEPTH - 1));
  assign stat_o.out_free = !out_valid_q || out_if.ready;

endmodule

`default_nettype wire

>>> design/sprite_pixel_blitter.sv
// Top level of the sprite pixel blitter: config registers, controller, datapath.
// Depends on spb_pkg, spb_if, spb_cfg_regs, spb_ctrl and spb_datapath.
`timescale 1ns / 1ps
`default_nettype none

// Sprite pixel blitter over a character-cell screen of MAX_WIDTH x MAX_HEIGHT cells,
// each holding a glyph byte and an attribute byte. A draw item stores its glyph and
// color|layer_bits into cell (col,row) unless the pixel is transparent, clipped, or
// (in plastic mode) lands on a foreground cell; a read item returns the cell. Every
// item gives exactly one result. An item goes through a transfer, a cell read, then
// decide/write and load of the result; the read-then-write of the single-port cell
// store sets that order. The next item is taken while a result waits in the output
// register, but the decide/write step holds until that register is free. After reset a
// clearing pass writes zero into all MAX_WIDTH*MAX_HEIGHT cells (4096 cells at the
// defaults), one per cycle, and no item is taken before it ends; configuration
// writes are taken at all times and should only be issued while the block is idle.
module sprite_pixel_blitter import spb_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  spb_in_if.sink                     in_if,
  spb_out_if.source                  out_if
);

  spb_cfg_t  cfg;
  spb_cmd_t  cmd;
  spb_stat_t stat;

  spb_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  spb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  spb_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .cmd_i  (cmd),
    .stat_o (stat),
    .in_if  (in_if),
    .out_if (out_if)
  );

endmodule

`default_nettype wire

>>> design/spb_checker.sv
// Port-level checks of the sprite pixel blitter, bound to the top level.
// Depends on spb_pkg and the assertion macros header.
`timescale 1ns / 1ps
`default_nettype none

`include "sprite_pixel_blitter_assert.svh"

module spb_checker import spb_pkg::*; (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_i,
  input wire logic               out_valid_i,
  input wire logic               out_ready_i,
  input wire logic               written_i,
  input wire logic [GLYPH_W-1:0] cell_glyph_i,
  input wire logic [ATTR_W-1:0]  cell_attr_i
);

  logic       in_xfer, out_xfer;
  logic       out_stall, out_wr;
  logic [GLYPH_W+ATTR_W:0] out_data;
  logic [2:0] pend_q, pend_d;

  // Track items taken but not yet delivered
  assign in_xfer  = in_valid_i && in_ready_i;
  assign out_xfer = out_valid_i && out_ready_i;

  // Result channel views
  assign out_stall = out_valid_i && !out_ready_i;
  assign out_wr    = out_valid_i && written_i;
  assign out_data  = {written_i, cell_glyph_i, cell_attr_i};

  always_comb begin
    pend_d = pend_q;
    if (in_xfer && !out_xfer) begin
      pend_d = pend_q + 3'd1;
    end else if (out_xfer && !in_xfer) begin
      pend_d = pend_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  `SPB_ASSERT_NEXT(a_out_hold, out_stall, out_valid_i, "result dropped while stalled")
  `SPB_ASSERT_NEXT(a_out_stable, out_stall, $stable(out_data), "result changed while stalled")
  `SPB_ASSERT(a_pend_bound, pend_q <= 3'd2, "more than two items in flight")
  `SPB_ASSERT_IMPLIES(a_no_phantom, out_valid_i, pend_q != 3'd0, "result without an item")
  `SPB_ASSERT_IMPLIES(a_write_attr, out_wr, cell_attr_i != '0, "stored cell has zero attr")

endmodule

bind sprite_pixel_blitter spb_checker u_spb_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_if.valid),
  .in_ready_i   (in_if.ready),
  .out_valid_i  (out_if.valid),
  .out_ready_i  (out_if.ready),
  .written_i    (out_if.written),
  .cell_glyph_i (out_if.cell_glyph),
  .cell_attr_i  (out_if.cell_attr)
);

`default_nettype wire

>>> tb/sprite_pixel_blitter_checker.sv
// Checker for the sprite pixel blitter: watches config, item and result transfers,
// keeps its own screen copy and compares every result. Depends on spb_pkg and spb_if.
`timescale 1ns / 1ps

module sprite_pixel_blitter_checker import spb_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  input  wire logic                  cfg_ready_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  spb_in_if                          in_mon,
  spb_out_if                         out_mon,
  output int                         fail_count_o,
  output int                         pending_o
);

  localparam int unsigned CELLS = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;

  typedef struct packed {
    logic               written;
    logic [GLYPH_W-1:0] glyph;
    logic [ATTR_W-1:0]  attr;
  } cell_result_t;

  // Screen copy and register copy
  logic [GLYPH_W-1:0] glyph_copy [CELLS];
  logic [ATTR_W-1:0]  attr_copy  [CELLS];
  logic [SW_W-1:0]    cur_width;
  logic [SH_W-1:0]    cur_height;
  logic [CODE_W-1:0]  cur_fg;
  logic [CODE_W-1:0]  cur_jfg;

  cell_result_t cell_result_q [$];
  cell_result_t oldest;
  int           mismatches = 0;
  int           waiting = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = waiting;

  // Print one line per mismatch and count it
  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch: %s got %0h want %0h", $time, what, got, want);
    mismatches++;
  endtask

  // Apply one draw or read item to the screen copy and return the cell result
  function automatic cell_result_t blit_pixel(logic kind, logic signed [COORD_W-1:0] col,
                                              logic signed [COORD_W-1:0] row,
                                              logic [GLYPH_W-1:0] glyph,
                                              logic [COLOR_W-1:0] color,
                                              logic [ATTR_W-1:0] layer, logic plastic);
    int           w;
    int           h;
    int           c;
    int           r;
    int unsigned  addr;
    logic [ATTR_W-1:0] hi;
    logic         do_wr;
    cell_result_t res;
    res = '0;
    // Oversized screen sizes act as the store size
    w = (cur_width > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(cur_width);
    h = (cur_height > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : int'(cur_height);
    c = int'(col);
    r = int'(row);
    // Clipped cell: all zero, nothing stored
    if (c < 0 || c >= w || r < 0 || r >= h) return res;
    addr = r * MAX_WIDTH_DEF + c;
    if (kind == KIND_DRAW) begin
      hi = (attr_copy[addr] & UPPER_NIBBLE_MASK) >> 4;
      do_wr = (color != '0) &&
              !(plastic && (hi[CODE_W-1:0] == cur_fg || hi[CODE_W-1:0] == cur_jfg));
      if (do_wr) begin
        glyph_copy[addr] = glyph;
        attr_copy[addr]  = {{(ATTR_W-COLOR_W){1'b0}}, color} | layer;
        res.written      = 1'b1;
      end
    end
    res.glyph = glyph_copy[addr];
    res.attr  = attr_copy[addr];
    return res;
  endfunction

  // Track registers, check results against the oldest prediction, predict new items
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CELLS; i++) begin
        glyph_copy[i] = '0;
        attr_copy[i]  = '0;
      end
      cur_width  = SCREEN_WIDTH_RST;
      cur_height = SCREEN_HEIGHT_RST;
      cur_fg     = FG_CODE_RST;
      cur_jfg    = JUMP_FG_CODE_RST;
      cell_result_q.delete();
      waiting = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_SCREEN_WIDTH: begin
            cur_width = cfg_data_i[SW_W-1:0];
          end
          REG_SCREEN_HEIGHT: begin
            cur_height = cfg_data_i[SH_W-1:0];
          end
          REG_FG_CODE: begin
            cur_fg = cfg_data_i[CODE_W-1:0];
          end
          REG_JUMP_FG_CODE: begin
            cur_jfg = cfg_data_i[CODE_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        if (cell_result_q.size() == 0) begin
          report_mismatch("result with no item waiting, glyph", out_mon.cell_glyph, 0);
        end else begin
          oldest = cell_result_q.pop_front();
          if (out_mon.written !== oldest.written)
            report_mismatch("written", out_mon.written, oldest.written);
          if (out_mon.cell_glyph !== oldest.glyph)
            report_mismatch("cell_glyph", out_mon.cell_glyph, oldest.glyph);
          if (out_mon.cell_attr !== oldest.attr)
            report_mismatch("cell_attr", out_mon.cell_attr, oldest.attr);
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        cell_result_q.push_back(blit_pixel(in_mon.kind, in_mon.col, in_mon.row,
                                           in_mon.glyph, in_mon.color,
                                           in_mon.layer_bits, in_mon.plastic));
      end
      waiting = cell_result_q.size();
    end
  end

endmodule

>>> tb/sprite_pixel_blitter_test.sv
// Testbench top of the sprite pixel blitter: clock, reset, config writes, items and
// receiver stalls. Depends on spb_pkg, spb_if, the block and the blitter checker.
`timescale 1ns / 1ps

module sprite_pixel_blitter_test;
  import spb_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic                      kind;
    logic signed [COORD_W-1:0] col;
    logic signed [COORD_W-1:0] row;
    logic [GLYPH_W-1:0]        glyph;
    logic [COLOR_W-1:0]        color;
    logic [ATTR_W-1:0]         layer_bits;
    logic                      plastic;
  } blit_item_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_req       = 1'b0;
  int cycle_count    = 0;
  int fail_count;
  int pending;

  // Screen settings as last written, used to aim the items
  logic [SW_W-1:0]   screen_w = SCREEN_WIDTH_RST;
  logic [SH_W-1:0]   screen_h = SCREEN_HEIGHT_RST;
  logic [CODE_W-1:0] fg_code  = FG_CODE_RST;
  logic [CODE_W-1:0] jfg_code = JUMP_FG_CODE_RST;

  spb_in_if  in_ch ();
  spb_out_if out_ch ();

  sprite_pixel_blitter u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_if       (in_ch),
    .out_if      (out_ch)
  );

  sprite_pixel_blitter_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #5 clk_i = ~clk_i;

  // End the run if it hangs
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("cycle limit of %0d reached, %0d results outstanding", CYCLE_LIMIT, pending);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Result receiver: random stalls, plus one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        for (int n = 0; n < HOLD_CYCLES; n++) begin
          out_ch.ready <= 1'b0;
          @(negedge clk_i);
        end
        hold_req = 1'b0;
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Leave cfg_valid high; the caller drops it after the last write
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
  endtask

  // Drop valid and wait until every predicted result has been taken
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Reprogram all registers once the block is idle
  task automatic set_screen(logic [7:0] w_data, logic [7:0] h_data,
                            logic [3:0] fg, logic [3:0] jfg);
    drain();
    write_reg(REG_SCREEN_WIDTH, w_data);
    write_reg(REG_SCREEN_HEIGHT, h_data);
    write_reg(REG_FG_CODE, {4'($urandom()), fg});
    write_reg(REG_JUMP_FG_CODE, {4'($urandom()), jfg});
    cfg_valid <= 1'b0;
    screen_w = w_data;
    screen_h = h_data[SH_W-1:0];
    fg_code  = fg;
    jfg_code = jfg;
  endtask

  // Offer one item after a random idle gap and hold it until it transfers
  task automatic send_item(blit_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.kind       <= it.kind;
    in_ch.col        <= it.col;
    in_ch.row        <= it.row;
    in_ch.glyph      <= it.glyph;
    in_ch.color      <= it.color;
    in_ch.layer_bits <= it.layer_bits;
    in_ch.plastic    <= it.plastic;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
  endtask

  function automatic blit_item_t draw_px(int c, int r, logic [7:0] g, logic [3:0] color,
                                         logic [7:0] layer, logic plastic);
    blit_item_t it;
    it.kind       = KIND_DRAW;
    it.col        = COORD_W'(c);
    it.row        = COORD_W'(r);
    it.glyph      = g;
    it.color      = color;
    it.layer_bits = layer;
    it.plastic    = plastic;
    return it;
  endfunction

  // Read with random content in the ignored fields
  function automatic blit_item_t read_px(int c, int r);
    blit_item_t it;
    it      = blit_item_t'({$urandom(), $urandom()});
    it.kind = KIND_READ;
    it.col  = COORD_W'(c);
    it.row  = COORD_W'(r);
    return it;
  endfunction

  // The whole area, a few hot cells near the origin, the edges and noise, by falling weight
  function automatic logic signed [COORD_W-1:0] pick_coord(int lim);
    int r;
    int hot;
    r   = $urandom_range(99);
    hot = (lim < 1) ? 1 : ((lim > 4) ? 4 : lim);
    if (r < 35) return COORD_W'($urandom_range(hot - 1));
    if (r < 75) return COORD_W'($urandom_range(lim + 1));
    if (r < 88) begin
      case ($urandom_range(2))
        0:       return COORD_W'(-1);
        1:       return COORD_W'(lim);
        default: return COORD_W'(lim - 1);
      endcase
    end
    return COORD_W'($urandom());
  endfunction

  function automatic blit_item_t random_item();
    blit_item_t  it;
    int          wl;
    int          hl;
    logic [3:0]  nib;
    wl = (screen_w > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(screen_w);
    hl = (screen_h > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : int'(screen_h);
    it.kind  = ($urandom_range(99) < 25) ? KIND_READ : KIND_DRAW;
    it.col   = pick_coord(wl);
    it.row   = pick_coord(hl);
    it.glyph = GLYPH_W'($urandom());
    it.color = ($urandom_range(99) < 15) ? '0 : COLOR_W'($urandom());
    // Bias the attribute's upper nibble toward the foreground codes
    case ($urandom_range(2))
      0:       nib = fg_code;
      1:       nib = jfg_code;
      default: nib = 4'($urandom());
    endcase
    it.layer_bits = {nib, 4'($urandom())};
    it.plastic    = 1'($urandom());
    return it;
  endfunction

  task automatic run_random(int n);
    repeat (n) send_item(random_item());
  endtask

  initial begin
    rst_ni           = 1'b0;
    cfg_valid        = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    in_ch.valid      = 1'b0;
    in_ch.kind       = KIND_DRAW;
    in_ch.col        = '0;
    in_ch.row        = '0;
    in_ch.glyph      = '0;
    in_ch.color      = '0;
    in_ch.layer_bits = '0;
    in_ch.plastic    = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed items at the reset settings, back to back on the same cells
    send_item(read_px(0, 0));
    send_item(draw_px(0, 0, 8'h41, 4'h5, 8'h10, 1'b0));
    send_item(draw_px(0, 0, 8'h42, 4'h7, 8'h00, 1'b1));   // foreground cell protected
    send_item(draw_px(0, 0, 8'h43, 4'h0, 8'hff, 1'b0));   // transparent
    send_item(draw_px(0, 0, 8'h41, 4'h5, 8'h10, 1'b0));   // same contents again
    send_item(draw_px(1, 0, 8'h5a, 4'h9, 8'h20, 1'b0));
    send_item(draw_px(1, 0, 8'h5b, 4'h3, 8'h00, 1'b1));   // jump-through cell protected
    send_item(draw_px(2, 0, 8'h61, 4'h1, 8'h30, 1'b1));
    send_item(draw_px(2, 0, 8'h62, 4'h2, 8'h00, 1'b1));   // other nibble not protected
    send_item(draw_px(79, 24, 8'hff, 4'hf, 8'hff, 1'b1));
    send_item(read_px(79, 24));
    send_item(draw_px(80, 0, 8'h11, 4'h4, 8'h00, 1'b0));
    send_item(draw_px(0, 25, 8'h12, 4'h4, 8'h00, 1'b0));
    send_item(draw_px(-1, 0, 8'h13, 4'h4, 8'h00, 1'b0));
    send_item(draw_px(0, -1, 8'h14, 4'h4, 8'h00, 1'b0));
    send_item(read_px(80, 24));
    send_item(draw_px(-2048, -2048, 8'haa, 4'ha, 8'h55, 1'b0));
    send_item(draw_px(2047, 2047, 8'h55, 4'h5, 8'haa, 1'b1));
    send_item(read_px(-2048, 2047));
    send_item(draw_px(3, 0, 8'h00, 4'hf, 8'h00, 1'b0));
    send_item(read_px(0, 0));
    send_item(read_px(1, 0));

    // Full store size, extreme codes; long receiver hold-off while items keep coming
    set_screen(8'd128, 8'd32, 4'd15, 4'd0);
    run_random(50);
    hold_req = 1'b1;
    run_random(60);

    // Single cell (height bits above the register are dropped), sender idling
    set_screen(8'd1, 8'h41, 4'd0, 4'd15);
    send_idle_pct = 58;
    run_random(60);

    // Small screen, equal codes, receiver stalling
    set_screen(8'd8, 8'd4, 4'd3, 4'd3);
    send_idle_pct  = 0;
    recv_stall_pct = 58;
    run_random(110);

    // Oversized screen, both sides idling
    set_screen(8'hff, 8'hff, 4'($urandom()), 4'($urandom()));
    send_idle_pct  = 14;
    recv_stall_pct = 14;
    run_random(100);

    // Zero width, then zero height: everything clipped
    set_screen(8'd0, 8'd5, 4'd1, 4'd2);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random(25);
    set_screen(8'd7, 8'hc0, 4'd2, 4'd1);
    run_random(25);

    // Random small screen, mixed idling, then a stretch with none
    set_screen(8'($urandom_range(24, 1)), 8'($urandom_range(10, 1)),
               4'($urandom()), 4'($urandom()));
    send_idle_pct  = 14;
    recv_stall_pct = 14;
    run_random(100);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random(40);

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
